// File: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAG_BITS  = 64;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_CMP = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [MAG_BITS-1:0] LIMIT =
      (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               is_equal;
      logic               is_less;
      logic [1:0]         status;
   } rsp_word_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_GCD_LOAD,
      S_GCD_DIV,
      S_GCD_WAIT,
      S_RED_NUM,
      S_RED_NUM_WAIT,
      S_RED_DEN,
      S_RED_DEN_WAIT,
      S_NORM_FIX,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_COMBINE,
      S_CHECK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_R
   } phase_type;

endpackage

// File: hw/rtl/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// add, multiply or compare two signed fractions with gcd reduction
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------------
//  request | start, busy, req_word         | taken when start && !busy
//  result  | rsp_valid, rsp_word           | one-cycle strobe, no back-pressure
//
// a zero denominator skips the reductions and goes straight to the result
// every euclid remainder step (data dependent, up to about 46 per operand and
// about 90 for the 64-bit result) and every exact division of a reduction
// runs on the shared divider; add and multiply run three reductions,
// compare runs two; cross products reuse one 32x32 multiplier
// reset clears the sequencer and the strobe; datapath registers hold garbage
// busy is high from acceptance until the result strobe; the receiver cannot
// stall, so the result is shown for exactly one cycle
module rational_arithmetic_unit_top
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // operand magnitudes and signs after decode / normalization
   logic [MAG_BITS-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic                ans_ff, ans_in, ads_ff, ads_in, bns_ff, bns_in, bds_ff, bds_in;
   logic [1:0]          op_ff, op_in;
   // working fraction under reduction
   logic [MAG_BITS-1:0] wn_ff, wn_in, wd_ff, wd_in, wns_ff_m;
   logic                wns_ff, wns_in, wds_ff, wds_in;
   // gcd registers
   logic [MAG_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in;
   // cross products
   logic [MAG_BITS-1:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [MAG_BITS-1:0] mul_a, mul_b, mul_p;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;

   div_ctl_type         dctl;
   div_sts_type         dsts;
   logic [MAG_BITS-1:0] d_dividend, d_divisor, d_quo, d_rem;

   rau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dctl),
      .dividend  (d_dividend),
      .divisor   (d_divisor),
      .sts       (dsts),
      .quotient  (d_quo),
      .remainder (d_rem)
   );

   // single 32x32 multiplier shared by all cross products
   assign mul_p = MAG_BITS'(mul_a[31:0]) * MAG_BITS'(mul_b[31:0]);
   assign wns_ff_m = wn_ff;

   function automatic logic [MAG_BITS-1:0] mag32(input logic signed [31:0] v);
      logic [MAG_BITS-1:0] e;
      e = MAG_BITS'(v[30:0]);
      if (v[31]) e = (MAG_BITS'(1) << 32) - MAG_BITS'(unsigned'(v));
      return e;
   endfunction

   always_comb begin
      logic [MAG_BITS:0] diff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ans_in = ans_ff; ads_in = ads_ff; bns_in = bns_ff; bds_in = bds_ff;
      op_in = op_ff;
      wn_in = wn_ff; wd_in = wd_ff; wns_in = wns_ff; wds_in = wds_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      p0_in = p0_ff; p1_in = p1_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      dctl.start   = 1'b0;
      d_dividend   = gx_ff;
      d_divisor    = gy_ff;
      mul_a        = an_ff;
      mul_b        = bd_ff;
      diff         = '0;

      case (state_ff)
         S_IDLE: begin
            // the strobe cycle still counts as busy
            if (start && !busy) begin
               op_in  = req_word.req_type;
               an_in  = mag32(req_word.a_num); ans_in = req_word.a_num[31];
               ad_in  = mag32(req_word.a_den); ads_in = req_word.a_den[31];
               bn_in  = mag32(req_word.b_num); bns_in = req_word.b_num[31];
               bd_in  = mag32(req_word.b_den); bds_in = req_word.b_den[31];
               wn_in  = mag32(req_word.a_num); wns_in = req_word.a_num[31];
               wd_in  = mag32(req_word.a_den); wds_in = req_word.a_den[31];
               phase_in = PH_A;
               if (req_word.a_den == '0 || req_word.b_den == '0) begin
                  rsp_in       = '0;
                  rsp_in.status = ST_ZERO_DEN;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_GCD_LOAD;
               end
            end
         end
         S_GCD_LOAD: begin
            gx_in    = wn_ff;
            gy_in    = wd_ff;
            state_in = S_GCD_DIV;
         end
         // euclid: x, y <- y, x mod y until y is zero
         S_GCD_DIV: begin
            if (gy_ff == '0) begin
               state_in = S_RED_NUM;
            end else begin
               dctl.start = 1'b1;
               state_in   = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (dsts.done) begin
               gx_in    = gy_ff;
               gy_in    = d_rem;
               state_in = S_GCD_DIV;
            end
         end
         S_RED_NUM: begin
            d_dividend = wn_ff;
            d_divisor  = gx_ff;
            dctl.start = 1'b1;
            state_in   = S_RED_NUM_WAIT;
         end
         S_RED_NUM_WAIT: begin
            if (dsts.done) begin
               wn_in    = d_quo;
               state_in = S_RED_DEN;
            end
         end
         S_RED_DEN: begin
            d_dividend = wd_ff;
            d_divisor  = gx_ff;
            dctl.start = 1'b1;
            state_in   = S_RED_DEN_WAIT;
         end
         S_RED_DEN_WAIT: begin
            if (dsts.done) begin
               wd_in    = d_quo;
               state_in = S_NORM_FIX;
            end
         end
         S_NORM_FIX: begin
            logic [MAG_BITS-1:0] fd;
            logic                fs;
            fs = wns_ff ^ wds_ff;
            fd = wd_ff;
            if (wns_ff_m == '0) begin
               fs = 1'b0;
               fd = MAG_BITS'(1);
            end
            case (phase_ff)
               PH_A: begin
                  an_in = wn_ff; ans_in = fs; ad_in = fd; ads_in = 1'b0;
                  wn_in = bn_ff; wns_in = bns_ff; wd_in = bd_ff; wds_in = bds_ff;
                  phase_in = PH_B;
                  state_in = S_GCD_LOAD;
               end
               PH_B: begin
                  bn_in = wn_ff; bns_in = fs; bd_in = fd; bds_in = 1'b0;
                  state_in = S_MUL0;
               end
               default: begin
                  rsp_in = '0;
                  if (wn_ff > LIMIT || fd > LIMIT) begin
                     rsp_in.status = ST_OVERFLOW;
                  end else begin
                     rsp_in.res_num = fs ? -signed'(wn_ff[31:0]) : signed'(wn_ff[31:0]);
                     rsp_in.res_den = fd[30:0];
                  end
                  state_in = S_DONE;
               end
            endcase
         end
         // p0 = an*bd, p1 = bn*ad (or an*bn for multiply), wd = ad*bd
         S_MUL0: begin
            mul_a = an_ff; mul_b = bd_ff;
            p0_in = mul_p;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            if (op_ff == OP_MUL) begin
               mul_a = an_ff; mul_b = bn_ff;
            end else begin
               mul_a = bn_ff; mul_b = ad_ff;
            end
            p1_in = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_a = ad_ff; mul_b = bd_ff;
            wd_in = mul_p; wds_in = 1'b0;
            state_in = op_ff[1] ? S_CHECK : S_COMBINE;
         end
         S_COMBINE: begin
            diff = {1'b0, p0_ff} - {1'b0, p1_ff};
            if (op_ff == OP_MUL) begin
               wn_in  = p1_ff;
               wns_in = (ans_ff ^ bns_ff) && p1_ff != '0;
            end else if (ans_ff == bns_ff) begin
               wn_in = p0_ff + p1_ff; wns_in = ans_ff;
            end else if (!diff[MAG_BITS]) begin
               wn_in = diff[MAG_BITS-1:0]; wns_in = ans_ff;
            end else begin
               wn_in = p1_ff - p0_ff; wns_in = bns_ff;
            end
            phase_in = PH_R;
            state_in = S_GCD_LOAD;
         end
         // compare on cross products; zero magnitudes carry positive sign
         S_CHECK: begin
            logic xs, ys;
            xs = ans_ff && p0_ff != '0;
            ys = bns_ff && p1_ff != '0;
            rsp_in = '0;
            rsp_in.is_equal = (ans_ff == bns_ff) && (an_ff == bn_ff) && (ad_ff == bd_ff);
            if (xs != ys)  rsp_in.is_less = xs;
            else if (xs)   rsp_in.is_less = p0_ff > p1_ff;
            else           rsp_in.is_less = p0_ff < p1_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ans_ff <= ans_in; ads_ff <= ads_in; bns_ff <= bns_in; bds_ff <= bds_in;
      op_ff <= op_in;
      wn_ff <= wn_in; wd_ff <= wd_in; wns_ff <= wns_in; wds_ff <= wds_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      p0_ff <= p0_in; p1_ff <= p1_in;
      rsp_ff <= rsp_in;
   end

   // busy covers the result strobe cycle too, so one word is in flight
   assign busy      = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: hw/rtl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_divider
   import rau_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_ctl_type         ctl,
   input  logic [MAG_BITS-1:0] dividend,
   input  logic [MAG_BITS-1:0] divisor,
   output div_sts_type         sts,
   output logic [MAG_BITS-1:0] quotient,
   output logic [MAG_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(MAG_BITS + 1);

   logic [MAG_BITS-1:0] quo_ff, quo_in;
   logic [MAG_BITS-1:0] rem_ff, rem_in;
   logic [MAG_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [MAG_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[MAG_BITS-1]} - {1'b0, dvs_ff};
      if (ctl.start && !busy_ff) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(MAG_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[MAG_BITS]) begin
            rem_in = trial[MAG_BITS-1:0];
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[MAG_BITS-2:0], quo_ff[MAG_BITS-1]};
            quo_in = {quo_ff[MAG_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks on the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker
   import rau_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // an accepted word makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // no strobe while idle the cycle before
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without request");

   // error results carry no fraction
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != ST_OK) |->
         (rsp_word.res_num == '0 && rsp_word.res_den == '0))
      else $error("error result not cleared");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

// File: bench/rational_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb
// self-checking bench: directed corner fractions then random add, multiply and
// compare words; every result strobe is checked against a gcd-reduced estimate
// ----------------------------------------------------------------------------

// holds the expected reduced fractions in order of acceptance
class fraction_scoreboard;
   rau_pkg::rsp_word_type pending_fractions[$];
   int                    mismatch_count = 0;

   // sign-magnitude split of a 32-bit two's complement field
   static function void split(input logic [31:0] raw, output bit neg,
                              output logic [63:0] mag);
      neg = raw[31];
      mag = neg ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
   endfunction

   static function logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // sign to numerator, both parts divided by their gcd, zero becomes 0/1
   static function void reduce(inout bit nn, inout logic [63:0] nm,
                               inout bit dn, inout logic [63:0] dm);
      logic [63:0] g;
      g = gcd64(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (dn) nn = !nn;
      dn = 0;
      if (nm == 0) begin
         nn = 0;
         dm = 1;
      end
   endfunction

   static function rau_pkg::rsp_word_type expected_fraction(input rau_pkg::req_word_type w);
      rau_pkg::rsp_word_type r;
      bit          an, ad, bn, bd, xn, yn, rn;
      logic [63:0] anm, adm, bnm, bdm, xm, ym, rnm, rdm;
      r = '0;
      split(w.a_num, an, anm);
      split(w.a_den, ad, adm);
      split(w.b_num, bn, bnm);
      split(w.b_den, bd, bdm);
      if (adm == 0 || bdm == 0) begin
         r.status = rau_pkg::ST_ZERO_DEN;
         return r;
      end
      reduce(an, anm, ad, adm);
      reduce(bn, bnm, bd, bdm);
      // cross products a_num*b_den and b_num*a_den, denominators positive now
      xm = anm * bdm;
      xn = an && xm != 0;
      ym = bnm * adm;
      yn = bn && ym != 0;
      if (w.req_type[1]) begin
         // compare, also taken by the unused code
         r.is_equal = (an == bn && anm == bnm && adm == bdm);
         if (xn != yn) r.is_less = xn;
         else if (xn) r.is_less = xm > ym;
         else r.is_less = xm < ym;
         return r;
      end
      if (w.req_type == rau_pkg::OP_ADD) begin
         if (xn == yn) begin
            rnm = xm + ym;
            rn  = xn;
         end else if (xm >= ym) begin
            rnm = xm - ym;
            rn  = xn;
         end else begin
            rnm = ym - xm;
            rn  = yn;
         end
         if (rnm == 0) rn = 0;
      end else begin
         rnm = anm * bnm;
         rn  = (an != bn) && rnm != 0;
      end
      rdm = adm * bdm;
      ad  = 0;
      reduce(rn, rnm, ad, rdm);
      if (rnm > rau_pkg::LIMIT || rdm > rau_pkg::LIMIT) begin
         r.status = rau_pkg::ST_OVERFLOW;
         return r;
      end
      r.res_num = rn ? -rnm[31:0] : rnm[31:0];
      r.res_den = rdm[30:0];
      r.status  = rau_pkg::ST_OK;
      return r;
   endfunction

   function void note_request(input rau_pkg::req_word_type w);
      pending_fractions.push_back(expected_fraction(w));
   endfunction

   task report(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch: %s", what);
   endtask

   task check_result(input rau_pkg::rsp_word_type got);
      rau_pkg::rsp_word_type exp_w;
      if (pending_fractions.size() == 0) begin
         report($sformatf("unexpected result word %h", got));
         return;
      end
      exp_w = pending_fractions.pop_front();
      if (got.res_num !== exp_w.res_num)
         report($sformatf("res_num %0d, expected %0d", got.res_num, exp_w.res_num));
      if (got.res_den !== exp_w.res_den)
         report($sformatf("res_den %0d, expected %0d", got.res_den, exp_w.res_den));
      if (got.is_equal !== exp_w.is_equal)
         report($sformatf("is_equal %b, expected %b", got.is_equal, exp_w.is_equal));
      if (got.is_less !== exp_w.is_less)
         report($sformatf("is_less %b, expected %b", got.is_less, exp_w.is_less));
      if (got.status !== exp_w.status)
         report($sformatf("status %0d, expected %0d", got.status, exp_w.status));
   endtask
endclass

module rational_arithmetic_unit_top_tb;
   import rau_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;   // cycles with no word moving
   localparam int RANDOM_WORDS   = 1700;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   fraction_scoreboard sb = new();
   int                 idle_cycles = 0;

   rational_arithmetic_unit_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // every strobe is one result word, checked at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_word);
   end

   // watchdog: counts cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hold start high until the word is taken (start && !busy at an edge)
   task send_word(input req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      sb.note_request(w);
   endtask

   task idle_gap(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task send_fraction(input logic [1:0] op, input int an, input int ad,
                      input int bn, input int bd);
      req_word_type w;
      w.req_type = op;
      w.a_num    = an;
      w.a_den    = ad;
      w.b_num    = bn;
      w.b_den    = bd;
      send_word(w);
   endtask

   // mostly small operands so gcds are nontrivial, some full 32-bit patterns
   function logic [31:0] random_field();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         3:       return 32'(-$urandom_range(0, 1000));
         4:       return $urandom_range(0, 65535) * $urandom_range(1, 360);
         5:       return 32'(-($urandom_range(0, 65535) * $urandom_range(1, 360)));
         default: return 32'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   function logic [31:0] random_den();
      if ($urandom_range(0, 39) == 0) return 32'h0;   // zero denominator now and then
      if ($urandom_range(0, 5) == 0) return 32'h1;     // integer operand
      return random_field();
   endfunction

   initial begin
      req_word_type w;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_fraction(OP_ADD, 1, 2, 1, 3);
      send_fraction(OP_MUL, 2, 4, -6, 9);
      send_fraction(OP_CMP, 1, 2, 2, 4);              // equal after reduction
      send_fraction(OP_CMP, -1, 3, 1, -4);            // sign carried by denominator
      send_fraction(OP_ADD, 5, 0, 1, 1);              // zero denominator, first operand
      send_fraction(OP_MUL, 1, 1, 3, 0);              // zero denominator, second operand
      send_fraction(OP_CMP, 0, 0, 0, 0);
      send_fraction(OP_ADD, 3, 7, -3, 7);             // zero sum gives 0/1
      send_fraction(OP_MUL, 0, -5, 9, 4);             // zero product
      send_fraction(OP_ADD, 32'h7fff_ffff, 1, 1, 1);  // overflow of the sum
      send_fraction(OP_MUL, 32'h8000_0000, 1, 1, 1);  // most negative, magnitude too big
      send_fraction(OP_MUL, 32'h8000_0000, 32'h8000_0000, 7, 3);
      send_fraction(OP_ADD, 32'h8000_0000, 2, 1, 1);
      send_fraction(OP_MUL, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_ffff);
      send_fraction(OP_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe); // denominator overflow
      send_fraction(OP_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
      send_fraction(OP_CMP, 32'h7fff_ffff, 1, 32'h8000_0000, 32'h8000_0000);
      send_fraction(OP_CMP, -5, -10, 1, 2);
      send_fraction(2'd3, 1, 3, 1, 2);                // unused code behaves as compare
      send_fraction(2'd3, 4, 6, -2, -3);
      send_fraction(OP_ADD, -1, -1, -1, 32'hffff_ffff);

      // let everything drain before the random part
      start <= 1'b0;
      while (sb.pending_fractions.size() != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         w.req_type = $urandom_range(0, 3);
         w.a_num    = random_field();
         w.a_den    = random_den();
         w.b_num    = random_field();
         w.b_den    = random_den();
         // same operand twice now and then, to hit equal compares and zero sums
         if ($urandom_range(0, 15) == 0) begin
            w.b_num = w.a_num;
            w.b_den = w.a_den;
         end
         send_word(w);
         // no idling in a long stretch in the middle
         if ((i < 500 || i >= 900) && $urandom_range(0, 99) < 35)
            idle_gap($urandom_range(1, 6));
      end
      start <= 1'b0;

      while (sb.pending_fractions.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
